// File: hw/rtl/tofs_pkg.sv
// Shared types, constants and helper functions of the operand fetch request sequencer.
package tofs_pkg;

    localparam int unsigned PACKET_BYTES      = 128;
    localparam int unsigned META_OFFSET_BYTES = 1024;
    localparam int unsigned JOB_Q_DEPTH       = 2;

    localparam logic [7:0]  META_PKT_BASE =
        8'((META_OFFSET_BYTES / PACKET_BYTES) % 256);
    localparam logic [31:0] PACKET_STEP       = 32'(PACKET_BYTES);
    localparam logic [31:0] CHUNK_BYTES_FP16  = 32'd512;
    localparam logic [31:0] CHUNK_BYTES_OTHER = 32'd256;

    localparam logic [1:0] FMT_FP8  = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_FP32 = 2'd2;

    localparam logic [1:0] SP_DENSE = 2'd0;
    localparam logic [1:0] SP_2OF4  = 2'd1;
    localparam logic [1:0] SP_1OF4  = 2'd2;

    localparam logic [1:0] CM_REUSE_1 = 2'd1;
    localparam logic [1:0] CM_REUSE_2 = 2'd2;

    localparam logic [2:0] KIND_A    = 3'd0;
    localparam logic [2:0] KIND_META = 3'd1;
    localparam logic [2:0] KIND_C    = 3'd2;
    localparam logic [2:0] KIND_B    = 3'd3;
    localparam logic [2:0] KIND_MARK = 3'd4;

    typedef struct packed {
        logic [1:0]  format_a;
        logic [1:0]  format_b;
        logic [1:0]  format_c;
        logic [1:0]  sparsity_mode;
        logic [2:0]  meta_select;
        logic [1:0]  collector_mode;
        logic        b_buffer_selected;
        logic        load_c;
        logic [31:0] a_tensor_addr;
        logic [31:0] d_tensor_addr;
        logic [13:0] b_start_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  request_kind;
        logic [31:0] tensor_addr;
        logic [7:0]  packet_index;
        logic [31:0] local_addr;
        logic [15:0] request_tag;
        logic [1:0]  chunk_index;
        logic        tile_start;
        logic        tile_end;
        logic        tile_has_c;
        logic        tile_has_meta;
        logic        last;
    } t_out_item;

    // Classified job handed from front to back
    typedef struct packed {
        logic [3:0]  na;
        logic        has_meta;
        logic [7:0]  meta_index;
        logic [4:0]  nc;
        logic        need_c;
        logic [3:0]  nb;
        logic [1:0]  last_chunk;
        logic        b_fp16;
        logic [31:0] b_base;
        logic [31:0] a_addr;
        logic [31:0] d_addr;
    } t_job;

    function automatic logic [3:0] ab_packets(input logic [1:0] fmt);
        logic [3:0] n;
        unique case (fmt)
            FMT_FP8:  n = 4'd4;
            FMT_FP16: n = 4'd8;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] acc_packets(input logic [1:0] fmt);
        logic [4:0] n;
        unique case (fmt)
            FMT_FP8:  n = 5'd4;
            FMT_FP16: n = 5'd8;
            FMT_FP32: n = 5'd16;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: hw/rtl/tofs_front.sv
// Front end: base register, job acceptance and classification into a job descriptor.
module tofs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  tofs_pkg::t_in_item i_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data,
    output logic              o_job_push,
    output tofs_pkg::t_job    o_job,
    input  logic              i_job_full
);

    logic [31:0] r_base;
    logic        reuse;
    logic        skip_a;
    logic        skip_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign full        = i_job_full;
    assign o_job_push  = push && !i_job_full;

    always_comb begin
        reuse  = (i_item.collector_mode == tofs_pkg::CM_REUSE_1) ||
                 (i_item.collector_mode == tofs_pkg::CM_REUSE_2);
        skip_a = reuse && !i_item.b_buffer_selected;
        skip_b = reuse && i_item.b_buffer_selected;

        o_job.na         = skip_a ? 4'd0 : tofs_pkg::ab_packets(i_item.format_a);
        o_job.has_meta   = !skip_a && (i_item.sparsity_mode != tofs_pkg::SP_DENSE);
        o_job.meta_index = tofs_pkg::META_PKT_BASE + {5'd0, i_item.meta_select};
        o_job.need_c     = i_item.load_c;
        o_job.nc         = i_item.load_c ? tofs_pkg::acc_packets(i_item.format_c) : 5'd0;
        o_job.nb         = skip_b ? 4'd0 : tofs_pkg::ab_packets(i_item.format_b);
        if (skip_b) begin
            o_job.last_chunk = 2'd0;
        end else if (i_item.sparsity_mode == tofs_pkg::SP_2OF4) begin
            o_job.last_chunk = 2'd1;
        end else if (i_item.sparsity_mode == tofs_pkg::SP_1OF4) begin
            o_job.last_chunk = 2'd3;
        end else begin
            o_job.last_chunk = 2'd0;
        end
        o_job.b_fp16 = (i_item.format_b == tofs_pkg::FMT_FP16);
        o_job.b_base = r_base + {14'd0, i_item.b_start_offset, 4'd0};
        o_job.a_addr = i_item.a_tensor_addr;
        o_job.d_addr = i_item.d_tensor_addr;
    end

endmodule

// File: hw/rtl/tofs_queue.sv
// Short job queue between the front end and the request sequencer.
module tofs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tofs_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output tofs_pkg::t_job o_data,
    output logic           o_empty
);

    localparam int unsigned PW = (tofs_pkg::JOB_Q_DEPTH > 1) ?
                                 $clog2(tofs_pkg::JOB_Q_DEPTH) : 1;
    localparam int unsigned CW = $clog2(tofs_pkg::JOB_Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(tofs_pkg::JOB_Q_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(tofs_pkg::JOB_Q_DEPTH);

    tofs_pkg::t_job r_mem [tofs_pkg::JOB_Q_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/tofs_back.sv
// Back end: walks one job through its request phases and holds the result register.
module tofs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tofs_pkg::t_job    i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    output tofs_pkg::t_out_item o_result,
    output logic              empty,
    input  logic              pop
);

    typedef enum logic [2:0] {
        S_IDLE, S_A, S_META, S_C, S_B, S_MARK
    } t_state;

    t_state              r_state, n_state;
    tofs_pkg::t_job      r_job, n_job;
    logic [4:0]          r_pkt, n_pkt;
    logic [1:0]          r_chunk, n_chunk;
    logic [31:0]         r_laddr, n_laddr;
    logic [31:0]         r_cbase, n_cbase;
    logic [15:0]         r_tag, n_tag;
    logic                r_out_valid, n_out_valid;
    tofs_pkg::t_out_item r_out, n_out;
    logic                adv;
    logic                load;
    logic [4:0]          pkt_inc;
    logic [31:0]         chunk_bytes;

    function automatic t_state first_phase(input t_state from, input tofs_pkg::t_job j);
        t_state s;
        priority if (from <= S_A && j.na != 4'd0) begin
            s = S_A;
        end else if (from <= S_META && j.has_meta) begin
            s = S_META;
        end else if (from <= S_C && j.nc != 5'd0) begin
            s = S_C;
        end else if (from <= S_B && j.nb != 4'd0) begin
            s = S_B;
        end else begin
            s = S_MARK;
        end
        return s;
    endfunction

    always_comb begin
        load        = (r_state == S_IDLE) && i_job_valid;
        adv         = (r_state != S_IDLE) && (!r_out_valid || pop);
        pkt_inc     = r_pkt + 5'd1;
        chunk_bytes = r_job.b_fp16 ? tofs_pkg::CHUNK_BYTES_FP16 : tofs_pkg::CHUNK_BYTES_OTHER;

        n_state     = r_state;
        n_job       = r_job;
        n_pkt       = r_pkt;
        n_chunk     = r_chunk;
        n_laddr     = r_laddr;
        n_cbase     = r_cbase;
        n_tag       = r_tag;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;

        if (load) begin
            n_job   = i_job;
            n_state = first_phase(S_A, i_job);
            n_pkt   = 5'd0;
            n_chunk = 2'd0;
            n_laddr = i_job.b_base;
            n_cbase = i_job.b_base;
        end

        if (adv) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.chunk_index = (r_state == S_B || r_state == S_MARK) ? r_chunk : 2'd0;
            if (r_state != S_MARK) begin
                n_out.request_tag = r_tag;
                n_tag = (r_tag == 16'hFFFF) ? 16'd1 : r_tag + 16'd1;
            end
            unique case (r_state)
                S_A: begin
                    n_out.request_kind = tofs_pkg::KIND_A;
                    n_out.tensor_addr  = r_job.a_addr;
                    n_out.packet_index = {3'd0, r_pkt};
                    if (pkt_inc == {1'b0, r_job.na}) begin
                        n_pkt   = 5'd0;
                        n_state = first_phase(S_META, r_job);
                    end else begin
                        n_pkt = pkt_inc;
                    end
                end
                S_META: begin
                    n_out.request_kind = tofs_pkg::KIND_META;
                    n_out.tensor_addr  = r_job.a_addr;
                    n_out.packet_index = r_job.meta_index;
                    n_state = first_phase(S_C, r_job);
                end
                S_C: begin
                    n_out.request_kind = tofs_pkg::KIND_C;
                    n_out.tensor_addr  = r_job.d_addr;
                    n_out.packet_index = {3'd0, r_pkt};
                    if (pkt_inc == r_job.nc) begin
                        n_pkt   = 5'd0;
                        n_state = first_phase(S_B, r_job);
                    end else begin
                        n_pkt = pkt_inc;
                    end
                end
                S_B: begin
                    n_out.request_kind = tofs_pkg::KIND_B;
                    n_out.packet_index = {3'd0, r_pkt};
                    n_out.local_addr   = r_laddr;
                    n_laddr = r_laddr + tofs_pkg::PACKET_STEP;
                    if (pkt_inc == {1'b0, r_job.nb}) begin
                        n_pkt   = 5'd0;
                        n_state = S_MARK;
                    end else begin
                        n_pkt = pkt_inc;
                    end
                end
                S_MARK: begin
                    n_out.request_kind  = tofs_pkg::KIND_MARK;
                    n_out.tile_start    = (r_chunk == 2'd0);
                    n_out.tile_end      = (r_chunk == r_job.last_chunk);
                    n_out.tile_has_c    = (r_chunk == 2'd0) && r_job.need_c;
                    n_out.tile_has_meta = (r_chunk == 2'd0) && r_job.has_meta;
                    n_out.last          = (r_chunk == r_job.last_chunk);
                    if (r_chunk == r_job.last_chunk) begin
                        n_state = S_IDLE;
                    end else begin
                        n_chunk = r_chunk + 2'd1;
                        n_cbase = r_cbase + chunk_bytes;
                        n_laddr = r_cbase + chunk_bytes;
                        n_state = (r_job.nb != 4'd0) ? S_B : S_MARK;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tag       <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tag       <= n_tag;
            r_out_valid <= n_out_valid;
        end
        r_job   <= n_job;
        r_pkt   <= n_pkt;
        r_chunk <= n_chunk;
        r_laddr <= n_laddr;
        r_cbase <= n_cbase;
        r_out   <= n_out;
    end

    assign o_job_pop = load;
    assign o_result  = r_out;
    assign empty     = !r_out_valid;

    a_tag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag != 16'd0)
        else $error("tag counter reached zero");

    a_marker_untagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.request_kind == tofs_pkg::KIND_MARK |-> r_out.request_tag == 16'd0)
        else $error("marker carries a tag");

    a_last_is_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> r_out.request_kind == tofs_pkg::KIND_MARK)
        else $error("last flag on a read");

    a_b_phase_has_packets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_B |-> r_job.nb != 4'd0)
        else $error("B phase entered with no B packets");

    a_tag_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_state != S_MARK && r_tag != 16'hFFFF |=> r_tag == $past(r_tag) + 16'd1)
        else $error("tag did not advance on a read");

endmodule

// File: hw/rtl/tensor_operand_fetch_request_sequencer.sv
// Top level of the tensor operand fetch request sequencer.
//
// Jobs enter on a queue-style port: a transfer happens when push is high and
// full is low. Each job is classified at once and parked in a two-entry job
// queue, so the front keeps taking jobs while the back end is busy.
// Results leave on a queue-style port: the oldest result sits on o_result
// while empty is low, and it is taken when pop is high and empty is low.
// The back end issues one result per cycle unless pop stalls it, in order:
// A reads, metadata, C reads, then per chunk the B reads and a tile marker
// (last on the final marker). A job yields at most 61 results; the back end
// loads a job descriptor only while idle, after the prior job's last marker.
// A new job passes the job queue and job register before its first result.
// If the receiver holds pop low, the result register holds and the back end
// stops; the job queue then fills and full rises.
// i_cfg_data writes the local memory base, always ready; write it only when
// the block is idle. Reset (synchronous, active low) clears the base to 0,
// the tag counter to 1, and empties both queues.
module tensor_operand_fetch_request_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tofs_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output tofs_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);

    tofs_pkg::t_job job_in;
    tofs_pkg::t_job job_out;
    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_empty;

    tofs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    tofs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    tofs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_valid (!job_empty),
        .o_job_pop   (job_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
